>>> rtl/dit_pkg.sv
// Shared types and codes for the document interval table.
`default_nettype none
package dit_pkg;
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BEFORE    = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_FIND = 1'b1;

   localparam int ID_WIDTH  = 64;
   localparam int LEN_WIDTH = 24;
   localparam int SEP_WIDTH = 8;
   localparam int OUT_POS_WIDTH = 32;
endpackage
`default_nettype wire

>>> rtl/document_interval_table.sv
// Document interval table: add documents end to end, find the one holding a position.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | operation, doc_id, doc_length, position
//  rsp     | out       | rsp_valid/rsp_ready  | status, found_id, found_start, found_length
//  csr     | in        | csr_write_enable     | csr_write_data (separator length)
//
// A find runs a binary search, each step an address, a registered read of the start
// table and a compare, then reads and checks the selected entry. An add runs a binary
// search over the sorted id table with the same steps, then shifts the ids above the
// insertion slot up one place, a read and a write per moved id through the single
// port.
// One item is in the block at a time; req_ready is low until the result is taken.
// Reset is synchronous: it clears the count and text end and sets the separator to one;
// stores need no clear.
`default_nettype none
module document_interval_table #(
   parameter int MAX_DOCS  = 1024,
   parameter int POS_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_operation,
   input  wire logic [dit_pkg::ID_WIDTH-1:0]  req_doc_id,
   input  wire logic [dit_pkg::LEN_WIDTH-1:0] req_doc_length,
   input  wire logic [dit_pkg::OUT_POS_WIDTH-1:0] req_position,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_status,
   output logic [dit_pkg::ID_WIDTH-1:0]       rsp_found_id,
   output logic [dit_pkg::OUT_POS_WIDTH-1:0]  rsp_found_start,
   output logic [dit_pkg::LEN_WIDTH-1:0]      rsp_found_length,
   input  wire logic                          csr_write_enable,
   input  wire logic [dit_pkg::SEP_WIDTH-1:0] csr_write_data
);
   import dit_pkg::*;

   localparam int AW = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
   localparam int CW = $clog2(MAX_DOCS + 1);
   localparam int PW = POS_WIDTH;
   localparam int EW = ((PW > OUT_POS_WIDTH) ? PW : OUT_POS_WIDTH) + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_ISRCH, S_IRD, S_ICMP, S_ADDCHK, S_SHRD, S_SHWT, S_SHWR, S_INS,
      S_FSRCH, S_FRD, S_FCMP, S_FSEL, S_FRD2, S_FCHK, S_RESP
   } state_type;

   // stores
   logic [ID_WIDTH-1:0]  id_mem    [MAX_DOCS];
   logic [ID_WIDTH-1:0]  eid_mem   [MAX_DOCS];
   logic [PW-1:0]        start_mem [MAX_DOCS];
   logic [LEN_WIDTH-1:0] len_mem   [MAX_DOCS];

   state_type            state_ff;
   logic [CW-1:0]        count_ff;
   logic [PW-1:0]        text_end_ff;
   logic [SEP_WIDTH-1:0] sep_ff;
   logic [ID_WIDTH-1:0]  id_ff;
   logic [LEN_WIDTH-1:0] len_ff;
   logic [OUT_POS_WIDTH-1:0] pos_ff;
   logic [CW-1:0]        lo_ff, hi_ff, idx_ff;
   logic [AW-1:0]        raddr_ff;
   logic [ID_WIDTH-1:0]  id_rd_ff, eid_rd_ff;
   logic [PW-1:0]        start_rd_ff;
   logic [LEN_WIDTH-1:0] len_rd_ff;
   logic [EW-1:0]        sum_ff;
   logic                 rsp_valid_ff;
   logic [2:0]           status_ff;
   logic [ID_WIDTH-1:0]  rid_ff;
   logic [OUT_POS_WIDTH-1:0] rstart_ff;
   logic [LEN_WIDTH-1:0] rlen_ff;

   logic                 id_we;
   logic [AW-1:0]        id_waddr;
   logic [ID_WIDTH-1:0]  id_wdata;
   logic                 ent_we;

   logic [CW-1:0] mid;
   logic [EW-1:0] limit;
   logic [EW-1:0] pos_ext;
   logic          id_lt;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign limit   = EW'({PW{1'b1}});
   assign id_lt   = $signed(id_rd_ff) < $signed(id_ff);
   assign pos_ext = EW'(pos_ff);

   always_comb begin
      id_we    = 1'b0;
      id_waddr = idx_ff[AW-1:0];
      id_wdata = id_rd_ff;
      ent_we   = 1'b0;
      if (state_ff == S_SHWR) begin
         id_we = 1'b1;
      end else if (state_ff == S_INS) begin
         id_we    = 1'b1;
         id_wdata = id_ff;
         ent_we   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      id_rd_ff <= id_mem[raddr_ff];
      if (id_we) id_mem[id_waddr] <= id_wdata;
   end

   always_ff @(posedge clock) begin
      eid_rd_ff   <= eid_mem[raddr_ff];
      start_rd_ff <= start_mem[raddr_ff];
      len_rd_ff   <= len_mem[raddr_ff];
      if (ent_we) begin
         eid_mem[count_ff[AW-1:0]]   <= id_ff;
         start_mem[count_ff[AW-1:0]] <= text_end_ff;
         len_mem[count_ff[AW-1:0]]   <= len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         text_end_ff  <= '0;
         sep_ff       <= SEP_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) sep_ff <= csr_write_data;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  id_ff  <= req_doc_id;
                  len_ff <= req_doc_length;
                  pos_ff <= req_position;
                  lo_ff  <= '0;
                  hi_ff  <= count_ff;
                  state_ff <= (req_operation == OP_ADD) ? S_ISRCH : S_FSRCH;
               end
            end
            // lower bound over sorted ids
            S_ISRCH: begin
               if (lo_ff < hi_ff) begin
                  raddr_ff <= mid[AW-1:0];
                  idx_ff   <= mid;
                  state_ff <= S_IRD;
               end else begin
                  raddr_ff <= lo_ff[AW-1:0];
                  idx_ff   <= lo_ff;
                  state_ff <= S_IRD;
                  hi_ff    <= lo_ff;
                  lo_ff    <= lo_ff + CW'(1);
               end
            end
            S_IRD: state_ff <= (lo_ff > hi_ff) ? S_ADDCHK : S_ICMP;
            S_ICMP: begin
               if (id_lt) lo_ff <= idx_ff + CW'(1);
               else hi_ff <= idx_ff;
               state_ff <= S_ISRCH;
            end
            S_ADDCHK: begin
               lo_ff <= hi_ff;  // slot
               sum_ff <= EW'(text_end_ff) + EW'(len_ff) + EW'(sep_ff);
               if (hi_ff < count_ff && id_rd_ff == id_ff) begin
                  status_ff <= ST_DUPLICATE;
                  state_ff  <= S_RESP;
               end else begin
                  idx_ff   <= count_ff;
                  state_ff <= S_SHRD;
               end
            end
            // full / overflow check, then move ids above the slot up one place
            S_SHRD: begin
               if (count_ff >= CW'(MAX_DOCS) || sum_ff > limit) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_RESP;
               end else if (idx_ff > lo_ff) begin
                  raddr_ff <= AW'(idx_ff - CW'(1));
                  state_ff <= S_SHWT;
               end else begin
                  idx_ff   <= lo_ff;
                  state_ff <= S_INS;
               end
            end
            // wait for the registered read of the id below
            S_SHWT: state_ff <= S_SHWR;
            S_SHWR: begin
               idx_ff   <= idx_ff - CW'(1);
               state_ff <= S_SHRD;
            end
            S_INS: begin
               count_ff    <= count_ff + CW'(1);
               text_end_ff <= sum_ff[PW-1:0];
               status_ff   <= ST_OK;
               rid_ff      <= id_ff;
               rstart_ff   <= OUT_POS_WIDTH'(text_end_ff);
               rlen_ff     <= len_ff;
               rsp_valid_ff <= 1'b1;
               state_ff    <= S_IDLE;
            end
            // upper bound over start positions
            S_FSRCH: begin
               if (count_ff == '0) begin
                  status_ff <= ST_EMPTY;
                  state_ff  <= S_RESP;
               end else if (lo_ff < hi_ff) begin
                  raddr_ff <= mid[AW-1:0];
                  idx_ff   <= mid;
                  state_ff <= S_FRD;
               end else if (lo_ff == '0) begin
                  status_ff <= ST_BEFORE;
                  state_ff  <= S_RESP;
               end else begin
                  raddr_ff <= AW'(lo_ff - CW'(1));
                  idx_ff   <= lo_ff;
                  state_ff <= S_FRD2;
               end
            end
            S_FRD: state_ff <= S_FCMP;
            S_FCMP: begin
               if (pos_ext < EW'(start_rd_ff)) hi_ff <= idx_ff;
               else lo_ff <= idx_ff + CW'(1);
               state_ff <= S_FSRCH;
            end
            S_FRD2: state_ff <= S_FSEL;
            S_FSEL: begin
               sum_ff <= EW'(start_rd_ff) + EW'(len_rd_ff)
                         + ((idx_ff != count_ff) ? EW'(sep_ff) : '0);
               state_ff <= S_FCHK;
            end
            S_FCHK: begin
               if (pos_ext >= EW'(start_rd_ff) && pos_ext < sum_ff) begin
                  status_ff    <= ST_OK;
                  rid_ff       <= eid_rd_ff;
                  rstart_ff    <= OUT_POS_WIDTH'(start_rd_ff);
                  rlen_ff      <= len_rd_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  status_ff <= ST_NOT_FOUND;
                  state_ff  <= S_RESP;
               end
            end
            S_RESP: begin
               rid_ff       <= '0;
               rstart_ff    <= '0;
               rlen_ff      <= '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_ready        = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_id     = rid_ff;
   assign rsp_found_start  = rstart_ff;
   assign rsp_found_length = rlen_ff;
endmodule
`default_nettype wire

>>> rtl/dit_checker.sv
// Port-level checker for the document interval table, bound to the top level.
`default_nettype none
module dit_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_status,
   input wire logic [63:0] rsp_found_id
);
   import dit_pkg::*;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready held after accept");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_found_id == '0)
      else $error("error result carries id");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd5) else $error("bad status");
endmodule

bind document_interval_table dit_checker u_dit_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_found_id(rsp_found_id)
);
`default_nettype wire

>>> test/interval_table_checker.sv
// Checker for the document interval table: predicts each response and compares it.
`timescale 1ns / 1ps
module interval_table_checker #(
   parameter int MAX_DOCS  = 1024,
   parameter int POS_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic                              req_operation,
   input  wire logic [dit_pkg::ID_WIDTH-1:0]      req_doc_id,
   input  wire logic [dit_pkg::LEN_WIDTH-1:0]     req_doc_length,
   input  wire logic [dit_pkg::OUT_POS_WIDTH-1:0] req_position,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic [2:0]                        rsp_status,
   input  wire logic [dit_pkg::ID_WIDTH-1:0]      rsp_found_id,
   input  wire logic [dit_pkg::OUT_POS_WIDTH-1:0] rsp_found_start,
   input  wire logic [dit_pkg::LEN_WIDTH-1:0]     rsp_found_length,
   input  wire logic                              csr_write_enable,
   input  wire logic [dit_pkg::SEP_WIDTH-1:0]     csr_write_data,
   output int                                     fail_count,
   output int                                     pending
);
   import dit_pkg::*;

   typedef struct packed {
      status_type                status;
      logic [ID_WIDTH-1:0]       id;
      logic [OUT_POS_WIDTH-1:0]  start;
      logic [LEN_WIDTH-1:0]      length;
   } lookup_result_type;

   logic [ID_WIDTH-1:0]  doc_ids [MAX_DOCS];
   longint unsigned      doc_starts [MAX_DOCS];
   logic [LEN_WIDTH-1:0] doc_lengths [MAX_DOCS];
   int                   doc_count;
   longint unsigned      text_end;
   logic [SEP_WIDTH-1:0] sep_length;
   lookup_result_type    expected_results [$];

   function automatic lookup_result_type apply_item(logic op, logic [ID_WIDTH-1:0] id,
                                                    logic [LEN_WIDTH-1:0] len,
                                                    logic [OUT_POS_WIDTH-1:0] pos);
      lookup_result_type r;
      longint unsigned new_end;
      longint unsigned span_end;
      longint unsigned pos_limit;
      int              hit;
      r = '{ST_OK, '0, '0, '0};
      pos_limit = (64'd1 << POS_WIDTH) - 1;
      if (op == OP_ADD) begin
         for (int i = 0; i < doc_count; i++)
            if (doc_ids[i] == id) begin
               r.status = ST_DUPLICATE;
               return r;
            end
         new_end = text_end + len + sep_length;
         if (doc_count >= MAX_DOCS || new_end > pos_limit) begin
            r.status = ST_FULL;
            return r;
         end
         doc_ids[doc_count]     = id;
         doc_starts[doc_count]  = text_end;
         doc_lengths[doc_count] = len;
         doc_count++;
         r.id     = id;
         r.start  = text_end[OUT_POS_WIDTH-1:0];
         r.length = len;
         text_end = new_end;
      end else begin
         if (doc_count == 0) begin
            r.status = ST_EMPTY;
            return r;
         end
         // starts never decrease: take the last entry starting at or before pos
         hit = -1;
         for (int i = 0; i < doc_count; i++)
            if (doc_starts[i] <= pos) hit = i;
         if (hit < 0) begin
            r.status = ST_BEFORE;
            return r;
         end
         span_end = doc_starts[hit] + doc_lengths[hit];
         if (hit != doc_count - 1) span_end += sep_length;
         if (pos < span_end) begin
            r.id     = doc_ids[hit];
            r.start  = doc_starts[hit][OUT_POS_WIDTH-1:0];
            r.length = doc_lengths[hit];
         end else begin
            r.status = ST_NOT_FOUND;
         end
      end
      return r;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         doc_count  = 0;
         text_end   = 0;
         sep_length = 1;
         expected_results.delete();
      end else begin
         if (csr_write_enable) sep_length = csr_write_data;
         if (req_valid && req_ready)
            expected_results.insert(expected_results.size(),
                                    apply_item(req_operation, req_doc_id,
                                               req_doc_length, req_position));
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response beat with nothing expected");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_found_id != want.id) begin
                  $error("found_id: expected %0h, got %0h", want.id, rsp_found_id);
                  fail_count++;
               end
               if (rsp_found_start != want.start) begin
                  $error("found_start: expected %0d, got %0d", want.start, rsp_found_start);
                  fail_count++;
               end
               if (rsp_found_length != want.length) begin
                  $error("found_length: expected %0d, got %0d", want.length,
                         rsp_found_length);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_results.size();
   end
endmodule

>>> test/testbench.sv
// Top of the document interval table testbench: stimulus, idling and verdict.
`timescale 1ns / 1ps
module testbench;
   import dit_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic                     req_operation;
   logic [ID_WIDTH-1:0]      req_doc_id;
   logic [LEN_WIDTH-1:0]     req_doc_length;
   logic [OUT_POS_WIDTH-1:0] req_position;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [2:0]               rsp_status;
   logic [ID_WIDTH-1:0]      rsp_found_id;
   logic [OUT_POS_WIDTH-1:0] rsp_found_start;
   logic [LEN_WIDTH-1:0]     rsp_found_length;
   logic                     csr_write_enable;
   logic [SEP_WIDTH-1:0]     csr_write_data;
   int                       fail_count;
   int                       pending;
   bit                       quiet;
   int                       ready_hold;
   int                       stall_cycles;
   logic [ID_WIDTH-1:0]      used_ids [$];
   longint unsigned          approx_end;

   document_interval_table u_top (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_doc_id,
      .req_doc_length, .req_position, .rsp_valid, .rsp_ready, .rsp_status,
      .rsp_found_id, .rsp_found_start, .rsp_found_length, .csr_write_enable,
      .csr_write_data
   );

   interval_table_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // response side: random stall bursts, none once quiet
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Drive one request beat at the falling edge and hold it until taken.
   task automatic send_item(logic op, logic [ID_WIDTH-1:0] id,
                            logic [LEN_WIDTH-1:0] len, logic [OUT_POS_WIDTH-1:0] pos);
      int gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_doc_id     <= id;
      req_doc_length <= len;
      req_position   <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_ADD) begin
         used_ids.insert(used_ids.size(), id);
         approx_end += len;
      end
   endtask

   // Drain every outstanding response, then write the separator.
   task automatic write_separator(logic [SEP_WIDTH-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_item(int find_pct, int dup_pct, bit big_len);
      logic [ID_WIDTH-1:0]      id;
      logic [LEN_WIDTH-1:0]     len;
      logic [OUT_POS_WIDTH-1:0] pos;
      id  = {$urandom, $urandom};
      if (used_ids.size() > 0 && $urandom_range(0, 99) < dup_pct)
         id = used_ids[$urandom_range(0, used_ids.size() - 1)];
      len = big_len ? LEN_WIDTH'($urandom_range(24'hF00000, 24'hFFFFFF))
          : ($urandom_range(0, 9) == 0) ? LEN_WIDTH'($urandom) : LEN_WIDTH'($urandom_range(0, 4095));
      pos = ($urandom_range(0, 4) == 0) ? $urandom
          : OUT_POS_WIDTH'($urandom_range(0, 32'(approx_end) + 64));
      send_item(($urandom_range(0, 99) < find_pct) ? OP_FIND : OP_ADD, id, len, pos);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_ADD;
      req_doc_id       = '0;
      req_doc_length   = '0;
      req_position     = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      quiet            = 1'b0;
      ready_hold       = 0;
      stall_cycles     = 0;
      approx_end       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // find on an empty table, then boundary ids, lengths and spans
      send_item(OP_FIND, '0, '0, '0);
      send_item(OP_FIND, '1, '1, '1);
      send_item(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
      send_item(OP_ADD, 64'h8000_0000_0000_0000, 24'hFFFFFF, '0);
      send_item(OP_ADD, 64'd0, 24'd5, '0);
      send_item(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 24'd9, '0);
      send_item(OP_ADD, '1, 24'd1, '0);
      send_item(OP_FIND, '0, '0, 32'd0);
      send_item(OP_FIND, '0, '0, 32'd1);
      send_item(OP_FIND, '0, '0, 32'd16777216);
      send_item(OP_FIND, '0, '0, 32'd16777217);
      send_item(OP_FIND, '0, '0, 32'd16777223);
      send_item(OP_FIND, '0, '0, 32'd16777224);
      send_item(OP_FIND, '0, '0, 32'hFFFF_FFFF);

      write_separator(SEP_WIDTH'($urandom_range(2, 254)));
      repeat (200) random_item(35, 15, 1'b0);

      // widest separator and longest documents: run the text end into overflow
      write_separator(8'hFF);
      repeat (330) random_item(12, 5, 1'b1);

      // no separator, empty documents: shared starts
      write_separator(8'h00);
      repeat (470) begin
         if ($urandom_range(0, 9) == 0)
            send_item(OP_FIND, '0, '0, $urandom_range(0, 3) == 0 ? $urandom : 32'hFFFF_FFFF);
         else
            send_item(OP_ADD, {$urandom, $urandom}, '0, '0);
      end

      quiet = 1'b1;
      repeat (40) random_item(50, 10, 1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
